// ----- rtl/nth_order_difference_core_defines.svh -----
// ---------------------------------------------------------------------------
// nth_order_difference_core_defines.svh
// Assertion macros shared by the difference core RTL.
// ---------------------------------------------------------------------------
`ifndef NTH_ORDER_DIFFERENCE_CORE_DEFINES_SVH
`define NTH_ORDER_DIFFERENCE_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define NDIFF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define NDIFF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define NDIFF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ndiff_pkg.sv -----
// ---------------------------------------------------------------------------
// ndiff_pkg
// Types and constants for the order-n difference core.
// ---------------------------------------------------------------------------
package ndiff_pkg;

  // Default sizing
  localparam int MAX_ORDER_DEFAULT  = 8;
  localparam int DATA_WIDTH_DEFAULT = 64;

  // Configuration register indexes
  localparam logic REG_ORDER      = 1'b0;
  localparam logic REG_WIDTH_MODE = 1'b1;

  // Configuration reset values
  localparam logic [3:0] ORDER_RESET      = 4'd1;
  localparam logic [1:0] WIDTH_MODE_RESET = 2'd3;

  // Input item
  typedef struct packed {
    logic [63:0] sample;
    logic        slice_end;
  } sample_t;

  // Result item
  typedef struct packed {
    logic [63:0] difference;
    logic        slice_done;
  } result_t;

  // Control that travels with an item down the cell chain
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } cell_ctrl_t;

endpackage

// ----- rtl/nth_order_difference_core.sv -----
// ---------------------------------------------------------------------------
// nth_order_difference_core
// Streaming order-n forward difference over slices, built as a chain of
// first-difference cells with wraparound at the configured element width.
// ---------------------------------------------------------------------------
//
//   channel  | handshake                     | payload
//   ---------+-------------------------------+---------------------------
//   input    | sample_valid / sample_ready   | sample_item (sample_t)
//   output   | result_valid / result_ready   | result_item (result_t)
//   config   | write_enable                  | write_index, write_data
//
// One item per cycle is accepted while sample_ready is high; each item is
// registered in each cell of the chain in turn before its result is shown.
// Items that give no result (the first n of a slice) leave the chain at
// its end without a handshake.
// Each cell holds its item until the next cell takes it, so a stalled
// output fills the chain before sample_ready drops.
// Synchronous reset clears the chain and the slice count and loads the
// register reset values; the stored previous values need no clearing.
// ---------------------------------------------------------------------------
`include "nth_order_difference_core_defines.svh"

module nth_order_difference_core #(
  parameter int MAX_ORDER  = ndiff_pkg::MAX_ORDER_DEFAULT,
  parameter int DATA_WIDTH = ndiff_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  ndiff_pkg::sample_t sample_item,
  output logic               result_valid,
  input  logic               result_ready,
  output ndiff_pkg::result_t result_item,
  input  logic               write_enable,
  input  logic               write_index,
  input  logic [3:0]         write_data
);

  localparam int OW = $clog2(MAX_ORDER + 1);

  logic [3:0]            order;
  logic [1:0]            width_mode;
  logic [OW-1:0]         seen_count;
  logic [OW-1:0]         order_eff;
  logic [DATA_WIDTH-1:0] mask;
  logic [DATA_WIDTH-1:0] final_value;
  logic                  accept;

  ndiff_pkg::cell_ctrl_t ctrl_chain [0:MAX_ORDER];
  logic [DATA_WIDTH-1:0] v_chain    [0:MAX_ORDER];
  logic [DATA_WIDTH-1:0] res_chain  [0:MAX_ORDER];
  logic                  ready_chain [0:MAX_ORDER];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order      <= ndiff_pkg::ORDER_RESET;
      width_mode <= ndiff_pkg::WIDTH_MODE_RESET;
    end else if (write_enable) begin
      case (write_index)
        ndiff_pkg::REG_ORDER:      order      <= write_data;
        ndiff_pkg::REG_WIDTH_MODE: width_mode <= write_data[1:0];
        default: ;
      endcase
    end
  end

  // Clamp the order to the chain length
  always_comb begin
    if (int'(order) > MAX_ORDER) begin
      order_eff = OW'(MAX_ORDER);
    end else begin
      order_eff = OW'(order);
    end
  end

  // Element mask, clamped to the data width
  always_comb begin
    int bits;
    bits = 8 << width_mode;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      mask[i] = (i < bits);
    end
  end

  // Count elements of the current slice, saturating
  assign accept = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      if (sample_item.slice_end) begin
        seen_count <= '0;
      end else if (seen_count < OW'(MAX_ORDER)) begin
        seen_count <= seen_count + 1'b1;
      end
    end
  end

  // Feed the head of the chain
  assign ctrl_chain[0].valid = sample_valid;
  assign ctrl_chain[0].emit  = (seen_count >= order_eff);
  assign ctrl_chain[0].last  = sample_item.slice_end;
  assign v_chain[0]          = sample_item.sample[DATA_WIDTH-1:0] & mask;
  assign res_chain[0]        = '0;
  assign sample_ready        = ready_chain[0];

  // Chain of difference cells
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    ndiff_cell #(
      .DATA_WIDTH  (DATA_WIDTH),
      .ORDER_WIDTH (OW),
      .INDEX       (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl_in   (ctrl_chain[k]),
      .v_in      (v_chain[k]),
      .res_in    (res_chain[k]),
      .order_eff (order_eff),
      .mask      (mask),
      .take      (ready_chain[k+1]),
      .ready     (ready_chain[k]),
      .ctrl_out  (ctrl_chain[k+1]),
      .v_out     (v_chain[k+1]),
      .res_out   (res_chain[k+1])
    );
  end

  // Drop items without a result at the tail; hold a result until taken
  assign result_valid           = ctrl_chain[MAX_ORDER].valid && ctrl_chain[MAX_ORDER].emit;
  assign ready_chain[MAX_ORDER] = !result_valid || result_ready;

  // Full-order result comes off the last difference
  assign final_value = (order_eff == OW'(MAX_ORDER)) ? v_chain[MAX_ORDER]
                                                     : res_chain[MAX_ORDER];

  assign result_item.difference = 64'(final_value & mask);
  assign result_item.slice_done = ctrl_chain[MAX_ORDER].last;

  // Assertions
  `NDIFF_ASSERT_ALWAYS(a_seen_bound, seen_count <= OW'(MAX_ORDER), "slice count past chain length")
  `NDIFF_ASSERT_NXT(a_slice_restart, accept && sample_item.slice_end, seen_count == '0, "slice count not cleared")
  `NDIFF_ASSERT_IMP(a_stall_cause, !sample_ready, result_valid && !result_ready, "input stalled without output stall")
  `NDIFF_ASSERT_IMP(a_mask_clean, result_valid, (final_value & ~mask) == '0, "result mask broken")

endmodule

// ----- rtl/ndiff_cell.sv -----
// ---------------------------------------------------------------------------
// ndiff_cell
// One first-difference cell: keeps the previous input it saw and passes
// the difference and the running result to the next cell.
// ---------------------------------------------------------------------------
module ndiff_cell #(
  parameter int DATA_WIDTH  = ndiff_pkg::DATA_WIDTH_DEFAULT,
  parameter int ORDER_WIDTH = 4,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ndiff_pkg::cell_ctrl_t  ctrl_in,
  input  logic [DATA_WIDTH-1:0]  v_in,
  input  logic [DATA_WIDTH-1:0]  res_in,
  input  logic [ORDER_WIDTH-1:0] order_eff,
  input  logic [DATA_WIDTH-1:0]  mask,
  input  logic                   take,
  output logic                   ready,
  output ndiff_pkg::cell_ctrl_t  ctrl_out,
  output logic [DATA_WIDTH-1:0]  v_out,
  output logic [DATA_WIDTH-1:0]  res_out
);

  logic [DATA_WIDTH-1:0] prev;

  // Load a new item when empty or when the held item moves on
  assign ready = !ctrl_out.valid || take;

  // Control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (ready) begin
      ctrl_out <= ctrl_in;
    end
  end

  // Difference wrapped to the element width, result tap and previous value
  always_ff @(posedge clk) begin
    if (ready && ctrl_in.valid) begin
      prev  <= v_in;
      v_out <= (v_in - prev) & mask;
      if (order_eff == ORDER_WIDTH'(INDEX)) begin
        res_out <= v_in;
      end else begin
        res_out <= res_in;
      end
    end
  end

endmodule

// ----- tb/nth_order_difference_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nth_order_difference_core_test
// Drives slices of samples through the difference core under several
// orders and element widths, predicts each order-n difference alongside
// the design, and checks every result item as it leaves the core.
// ---------------------------------------------------------------------------
module nth_order_difference_core_test;

  localparam int MAX_ORDER  = ndiff_pkg::MAX_ORDER_DEFAULT;
  localparam int DRAIN_WAIT = MAX_ORDER + 4;

  logic               clk;
  logic               rst          = 1'b1;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  ndiff_pkg::sample_t sample_item  = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  ndiff_pkg::result_t result_item;
  logic               write_enable = 1'b0;
  logic               write_index  = ndiff_pkg::REG_ORDER;
  logic [3:0]         write_data   = '0;

  // Shadow of the core's registers and slice state
  logic [3:0]  cfg_order      = ndiff_pkg::ORDER_RESET;
  logic [1:0]  cfg_width_mode = ndiff_pkg::WIDTH_MODE_RESET;
  logic [63:0] diff_prev [MAX_ORDER];
  int          slice_seen     = 0;

  ndiff_pkg::result_t pending_diffs [$];
  ndiff_pkg::result_t head_diff;
  int      mismatches     = 0;
  int      sender_idle_pct = 0;
  int      rx_stall_pct    = 0;
  int      rx_hold         = 0;
  int      slice_left      = 0;

  nth_order_difference_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("nth_order_difference_core_test: done, errors");
    $finish;
  end

  function automatic logic [63:0] width_mask(input logic [1:0] wm);
    if (wm == 2'd3) return '1;
    return (64'd1 << (8 << wm)) - 64'd1;
  endfunction

  // Run one sample through the shadow cascade; return 1 when it gives a result
  function automatic bit predict_difference(input ndiff_pkg::sample_t it,
                                            output ndiff_pkg::result_t diff);
    logic [63:0] m;
    logic [63:0] v;
    logic [63:0] d;
    logic [63:0] picked;
    int          n;
    bit          walking;
    bit          gives;
    m       = width_mask(cfg_width_mode);
    v       = it.sample & m;
    n       = (cfg_order > MAX_ORDER) ? MAX_ORDER : int'(cfg_order);
    picked  = '0;
    walking = 1'b1;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (walking) begin
        if (k == n) picked = v;
        if (slice_seen <= k) begin
          diff_prev[k] = v;
          walking      = 1'b0;
        end else begin
          d            = (v - diff_prev[k]) & m;
          diff_prev[k] = v;
          v            = d;
        end
      end
    end
    if (n == MAX_ORDER && slice_seen >= MAX_ORDER) picked = v;
    diff.difference = picked & m;
    diff.slice_done = it.slice_end;
    gives = (slice_seen >= n);
    if (it.slice_end) slice_seen = 0;
    else if (slice_seen < MAX_ORDER) slice_seen++;
    return gives;
  endfunction

  // Output side: random stalls, plus a counted hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      result_ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_diffs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: difference=%h slice_done=%b",
                   result_item.difference, result_item.slice_done);
      end else begin
        head_diff = pending_diffs.pop_front();
        if (result_item.difference !== head_diff.difference ||
            result_item.slice_done !== head_diff.slice_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected difference=%h slice_done=%b, got %h %b",
                     head_diff.difference, head_diff.slice_done,
                     result_item.difference, result_item.slice_done);
        end
      end
    end
  end

  // Offer one item after a random gap; hold it until accepted
  task automatic send_sample(input logic [63:0] value, input logic last);
    ndiff_pkg::sample_t it;
    ndiff_pkg::result_t diff;
    it.sample    = value;
    it.slice_end = last;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= it;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    if (predict_difference(it, diff)) pending_diffs.push_back(diff);
  endtask

  // Drop valid and wait until the core has emptied
  task automatic drain;
    sample_valid <= 1'b0;
    while (pending_diffs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write both registers while the core is idle
  task automatic set_config(input logic [3:0] ord, input logic [3:0] wm);
    drain();
    write_enable <= 1'b1;
    write_index  <= ndiff_pkg::REG_ORDER;
    write_data   <= ord;
    @(posedge clk);
    cfg_order    = ord;
    write_index  <= ndiff_pkg::REG_WIDTH_MODE;
    write_data   <= wm;
    @(posedge clk);
    cfg_width_mode = wm[1:0];
    write_enable <= 1'b0;
  endtask

  function automatic logic [63:0] random_sample;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Next item of the random slice stream; slices carry across config writes
  task automatic send_random_sample;
    if (slice_left == 0)
      slice_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 24);
    slice_left--;
    send_sample(random_sample(), slice_left == 0);
  endtask

  // Reset config, order 0 copy, oversized order, short slice, mid-slice change
  task automatic test_directed;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    send_sample(64'h0, 1'b0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h0, 1'b1);
    set_config(4'd0, 4'd0);
    send_sample(64'hFFFF_FFFF_FFFF_FF80, 1'b1);
    set_config(4'd9, 4'd2);
    for (int i = 0; i < 9; i++)
      send_sample((i % 2) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_0000_0001 * i, i == 8);
    set_config(4'd3, 4'd1);
    send_sample(64'h1234, 1'b0);
    send_sample(64'hFFFF, 1'b0);
    send_sample(64'h8000, 1'b1);
    set_config(4'd2, 4'd3);
    send_sample(64'h8000_0000_0000_0000, 1'b0);
    send_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    set_config(4'd1, 4'd1);
    send_sample(64'hABCD_0000_0000_0001, 1'b0);
    send_sample(64'h0, 1'b0);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
  endtask

  // Hold the output off long enough for the chain to fill and stall input
  task automatic test_backpressure;
    set_config(4'd1, 4'd3);
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    rx_hold <= 300;
    for (int i = 0; i < 40; i++) send_sample(random_sample(), i == 39);
    drain();
  endtask

  // Random slices in chunks, reconfiguring between chunks
  task automatic test_random_phase(input int idle, input int stall, input int count,
                                   input logic [3:0] first_order, input logic [3:0] first_wm);
    int sent;
    int chunk;
    sent = 0;
    set_config(first_order, first_wm);
    sender_idle_pct = idle;
    rx_stall_pct    = stall;
    while (sent < count) begin
      chunk = $urandom_range(20, 80);
      repeat (chunk) send_random_sample();
      sent += chunk;
      if (sent < count)
        set_config(4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                  : $urandom_range(0, 8)),
                   4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 300, 4'd8, 4'd0);
    test_random_phase(71, 0, 300, 4'd15, 4'd3);
    test_random_phase(0, 71, 300, 4'd0, 4'd1);
    test_random_phase(26, 26, 300, 4'd7, 4'd2);
    drain();
    mismatches += pending_diffs.size();
    if (mismatches == 0) begin
      $display("nth_order_difference_core_test: done, clean");
    end else begin
      $display("nth_order_difference_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ndiff_pkg.sv
rtl/ndiff_cell.sv
rtl/nth_order_difference_core.sv
tb/nth_order_difference_core_test.sv
